// ===== sv/v3n_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;
    localparam int unsigned CompWidth = 32;
    localparam int unsigned MagWidth = 33;          // |component| up to 2^31
    localparam int unsigned SumWidth = 64;
    localparam int unsigned RootWidth = 32;
    localparam int unsigned QuoWidth = 31;          // quotient up to 2^30
    localparam int unsigned DivStages = QuoWidth;
    localparam int unsigned RemWidth = RootWidth + 1;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] x_unit;
        logic signed [31:0] y_unit;
        logic signed [31:0] z_unit;
        logic [31:0]        magnitude;
        logic               zero_length;
    } t_out_item;

    // sideband carried along the chains
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } t_ctl;
endpackage
`default_nettype wire

// ===== sv/v3n_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring square-root step: two radicand bits, one root bit.
module v3n_sqrt_cell
    import v3n_pkg::*;
#(
    parameter int unsigned Step = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_ctl                  i_ctl,
    input  wire logic [SumWidth-1:0]   i_rad,
    input  wire logic [RootWidth:0]    i_rem,
    input  wire logic [RootWidth-1:0]  i_root,
    input  wire logic [3*MagWidth-1:0] i_mags,
    output t_ctl                       o_ctl,
    output logic [SumWidth-1:0]        o_rad,
    output logic [RootWidth:0]         o_rem,
    output logic [RootWidth-1:0]       o_root,
    output logic [3*MagWidth-1:0]      o_mags
);
    localparam int unsigned Hi = SumWidth - 1 - 2 * Step;

    logic [RootWidth+2:0] trial, cur;
    logic [RootWidth:0]   n_rem;
    logic [RootWidth-1:0] n_root;
    t_ctl                 r_ctl;
    logic [SumWidth-1:0]  r_rad;
    logic [RootWidth:0]   r_rem;
    logic [RootWidth-1:0] r_root;
    logic [3*MagWidth-1:0] r_mags;

    always_comb begin
        cur   = {i_rem, i_rad[Hi -: 2]};
        trial = {1'b0, i_root, 2'b01};
        if (cur >= trial) begin
            n_rem  = RemWidth'(cur - trial);
            n_root = {i_root[RootWidth-2:0], 1'b1};
        end else begin
            n_rem  = RemWidth'(cur);
            n_root = {i_root[RootWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mags <= i_mags;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_mags = r_mags;
endmodule
`default_nettype wire

// ===== sv/v3n_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring division step for three dividends sharing a divisor.
module v3n_div_cell
    import v3n_pkg::*;
#(
    parameter int unsigned Step = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire t_ctl                   i_ctl,
    input  wire logic [RootWidth-1:0]   i_den,
    input  wire logic [3*MagWidth-1:0]  i_mags,
    input  wire logic [3*RemWidth-1:0]  i_rems,
    input  wire logic [3*QuoWidth-1:0]  i_quos,
    output t_ctl                        o_ctl,
    output logic [RootWidth-1:0]        o_den,
    output logic [3*MagWidth-1:0]       o_mags,
    output logic [3*RemWidth-1:0]       o_rems,
    output logic [3*QuoWidth-1:0]       o_quos
);
    // dividend is mag << 30, a 63-bit value; bit fed in this step
    localparam int unsigned DBit = QuoWidth - 1 - Step;
    localparam int unsigned Shift = QuoWidth - 1;

    logic [3*RemWidth-1:0] n_rems;
    logic [3*QuoWidth-1:0] n_quos;
    logic [RemWidth:0]     cur;
    logic [MagWidth+Shift-1:0] dvd;
    t_ctl                  r_ctl;
    logic [RootWidth-1:0]  r_den;
    logic [3*MagWidth-1:0] r_mags;
    logic [3*RemWidth-1:0] r_rems;
    logic [3*QuoWidth-1:0] r_quos;

    always_comb begin
        n_rems = '0;
        n_quos = '0;
        for (int k = 0; k < 3; k++) begin
            dvd = {i_mags[k*MagWidth +: MagWidth], Shift'(0)};
            // quotient bits above QuoWidth are zero since |c| <= len
            if (Step == 0) begin
                cur = (RemWidth+1)'(dvd >> DBit);
            end else begin
                cur = {i_rems[k*RemWidth +: RemWidth], dvd[DBit]};
            end
            if (cur >= {2'b00, i_den}) begin
                n_rems[k*RemWidth +: RemWidth] = RemWidth'(cur - {2'b00, i_den});
                n_quos[k*QuoWidth +: QuoWidth] =
                    {i_quos[k*QuoWidth +: QuoWidth-1], 1'b1};
            end else begin
                n_rems[k*RemWidth +: RemWidth] = RemWidth'(cur);
                n_quos[k*QuoWidth +: QuoWidth] =
                    {i_quos[k*QuoWidth +: QuoWidth-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_den  <= i_den;
            r_mags <= i_mags;
            r_rems <= n_rems;
            r_quos <= n_quos;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_den  = r_den;
    assign o_mags = r_mags;
    assign o_rems = r_rems;
    assign o_quos = r_quos;
endmodule
`default_nettype wire

// ===== sv/vec3_normalize_length.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 1 input register + 2 squaring stages + 32 root cells + 31 divide cells,
// 66 register stages in all.
// Throughput: one item per cycle; the whole chain advances when the output is not stalled.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
module vec3_normalize_length
    import v3n_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);
    localparam int unsigned RootCells = RootWidth;

    logic en;
    // chain moves when the final register is empty or being taken
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 0: magnitudes and signs
    t_ctl                  r_c0;
    logic [3*MagWidth-1:0] r_m0;
    logic [MagWidth-1:0]   a0, a1, a2;
    always_comb begin
        a0 = i_item.x_in[31] ? MagWidth'(-{1'b1, i_item.x_in}) : MagWidth'(i_item.x_in);
        a1 = i_item.y_in[31] ? MagWidth'(-{1'b1, i_item.y_in}) : MagWidth'(i_item.y_in);
        a2 = i_item.z_in[31] ? MagWidth'(-{1'b1, i_item.z_in}) : MagWidth'(i_item.z_in);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
        end else if (en) begin
            r_c0.valid <= i_valid;
            r_c0.zero  <= (i_item.x_in == 0) && (i_item.y_in == 0) && (i_item.z_in == 0);
            r_c0.neg   <= {i_item.z_in[31], i_item.y_in[31], i_item.x_in[31]};
        end
        if (en) begin
            r_m0 <= {a2, a1, a0};
        end
    end

    // stage 1: three squares
    t_ctl                  r_c1;
    logic [3*MagWidth-1:0] r_m1;
    logic [2*MagWidth-1:0] sq [3];
    logic [SumWidth-1:0]   r_sq [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq[k] = r_m0[k*MagWidth +: MagWidth] * r_m0[k*MagWidth +: MagWidth];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
        end else if (en) begin
            r_c1 <= r_c0;
        end
        if (en) begin
            r_m1 <= r_m0;
            for (int k = 0; k < 3; k++) begin
                // square of a 2^31 magnitude still fits in 64 bits
                r_sq[k] <= sq[k][SumWidth-1:0];
            end
        end
    end

    // stage 2: sum of squares
    t_ctl                  r_c2;
    logic [3*MagWidth-1:0] r_m2;
    logic [SumWidth-1:0]   r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
        end else if (en) begin
            r_c2 <= r_c1;
        end
        if (en) begin
            r_m2  <= r_m1;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // square-root chain
    t_ctl                  sc [RootCells+1];
    logic [SumWidth-1:0]   srad [RootCells+1];
    logic [RootWidth:0]    srem [RootCells+1];
    logic [RootWidth-1:0]  sroot [RootCells+1];
    logic [3*MagWidth-1:0] smag [RootCells+1];
    assign sc[0]    = r_c2;
    assign srad[0]  = r_sum;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign smag[0]  = r_m2;
    for (genvar g = 0; g < RootCells; g++) begin : g_sqrt
        v3n_sqrt_cell #(.Step(g)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_ctl(sc[g]), .i_rad(srad[g]), .i_rem(srem[g]), .i_root(sroot[g]),
            .i_mags(smag[g]),
            .o_ctl(sc[g+1]), .o_rad(srad[g+1]), .o_rem(srem[g+1]), .o_root(sroot[g+1]),
            .o_mags(smag[g+1])
        );
    end

    // divider chain; magnitude rides along as the divisor
    t_ctl                  dc [DivStages+1];
    logic [RootWidth-1:0]  dden [DivStages+1];
    logic [3*MagWidth-1:0] dmag [DivStages+1];
    logic [3*RemWidth-1:0] drem [DivStages+1];
    logic [3*QuoWidth-1:0] dquo [DivStages+1];
    assign dc[0]   = sc[RootCells];
    assign dden[0] = sroot[RootCells];
    assign dmag[0] = smag[RootCells];
    assign drem[0] = '0;
    assign dquo[0] = '0;
    for (genvar g = 0; g < DivStages; g++) begin : g_div
        v3n_div_cell #(.Step(g)) u_cell (
            .i_clk, .i_rst_n, .i_en(en),
            .i_ctl(dc[g]), .i_den(dden[g]), .i_mags(dmag[g]), .i_rems(drem[g]),
            .i_quos(dquo[g]),
            .o_ctl(dc[g+1]), .o_den(dden[g+1]), .o_mags(dmag[g+1]), .o_rems(drem[g+1]),
            .o_quos(dquo[g+1])
        );
    end

    // sign restore; zero vector gives all zero with flag
    t_ctl                 fc;
    logic [QuoWidth-1:0]  q [3];
    logic [31:0]          u [3];
    always_comb begin
        fc = dc[DivStages];
        for (int k = 0; k < 3; k++) begin
            q[k] = dquo[DivStages][k*QuoWidth +: QuoWidth];
            u[k] = fc.neg[k] ? -{1'b0, q[k]} : {1'b0, q[k]};
            if (fc.zero) begin
                u[k] = '0;
            end
        end
    end

    assign o_valid            = fc.valid;
    assign o_item.x_unit      = u[0];
    assign o_item.y_unit      = u[1];
    assign o_item.z_unit      = u[2];
    assign o_item.magnitude   = dden[DivStages];
    assign o_item.zero_length = fc.zero;
endmodule
`default_nettype wire

// ===== bench/vec3_normalize_length_tb.sv =====
`timescale 1ns / 1ps
module vec3_normalize_length_tb;
    import v3n_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    vec3_normalize_length u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // pipeline depth; sets the drain margin at the end
    localparam int PipeDepth = 66;

    t_out_item unit_q[$];      // expected normalized results, oldest first
    int        n_mismatch = 0;
    bit        hold_rx = 0;    // long receiver hold-off in progress
    bit        sender_busy = 0;
    int        rx_wait = 0;    // cycles left in the receiver's current wait

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // exact floor square root of a 64-bit sum, bit-serial
    function automatic logic [63:0] isqrt64(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s = s - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_comp(logic signed [31:0] c, logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        m = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
        q = (m << 30) / len;
        if (c[31]) q = -q;
        return q[31:0];
    endfunction

    function automatic t_out_item normalize(t_in_item v);
        t_out_item   r;
        logic [63:0] ax, ay, az, sum, len;
        ax = v.x_in[31] ? (64'h1_0000_0000 - {32'd0, v.x_in}) : {32'd0, v.x_in};
        ay = v.y_in[31] ? (64'h1_0000_0000 - {32'd0, v.y_in}) : {32'd0, v.y_in};
        az = v.z_in[31] ? (64'h1_0000_0000 - {32'd0, v.z_in}) : {32'd0, v.z_in};
        sum = ax * ax + ay * ay + az * az;
        r = '0;
        if (sum == 0) begin
            r.zero_length = 1'b1;
        end else begin
            len = isqrt64(sum);
            r.x_unit = unit_comp(v.x_in, len);
            r.y_unit = unit_comp(v.y_in, len);
            r.z_unit = unit_comp(v.z_in, len);
            r.magnitude = len[31:0];
        end
        return r;
    endfunction

    // offer one item after a random gap; prediction made on acceptance.
    // valid drops only for a gap, so back-to-back items keep it high.
    task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= '{x_in: x, y_in: y, z_in: z};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        unit_q.push_back(normalize('{x_in: x, y_in: y, z_in: z}));
    endtask

    // Receiver stall: per-item random wait, or a forced long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            i_stall <= (rx_wait != 0);
        end else if (o_valid && !i_stall) begin
            // just accepted one; wait before the next
            rx_wait = $urandom_range(0, 17);
            i_stall <= (rx_wait != 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (unit_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", o_item);
            end else begin
                want = unit_q.pop_front();
                if (want.x_unit !== o_item.x_unit || want.y_unit !== o_item.y_unit ||
                    want.z_unit !== o_item.z_unit || want.magnitude !== o_item.magnitude ||
                    want.zero_length !== o_item.zero_length) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h m=%h zl=%b",
                                 want.x_unit, want.y_unit, want.z_unit, want.magnitude,
                                 want.zero_length,
                                 " got x=%h y=%h z=%h m=%h zl=%b",
                                 o_item.x_unit, o_item.y_unit,
                                 o_item.z_unit, o_item.magnitude, o_item.zero_length);
                end
            end
        end
    end

    // Directed: zero vector, single axes, extremes, sign edges.
    task automatic test_corners();
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        send_vec(0, 0, 0);
        send_vec(32'h0001_0000, 0, 0);
        send_vec(0, 32'hffff_0000, 0);
        send_vec(0, 0, 32'd1);
        send_vec(32'hffff_ffff, 0, 0);
        send_vec(mn, 0, 0);
        send_vec(mx, 0, 0);
        send_vec(mn, mn, mn);
        send_vec(mx, mx, mx);
        send_vec(mx, mn, mx);
        send_vec(mn, mx, 32'd1);
        send_vec(32'd1, 32'd1, 32'd1);
        send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vec(32'd3, 32'd4, 0);
        send_vec(32'hfffd_0000, 0, 32'h0004_0000);
        send_vec(32'd1, mx, 0);
        send_vec(0, 32'd1, mn);
        send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 40) - 20;          // tiny
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 9)
                                            : 32'h8000_0000 + $urandom_range(0, 9);
            4: return 0;
            default: return $urandom() >>> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic test_random(int count);
        repeat (count) send_vec(rand_comp(), rand_comp(), rand_comp());
    endtask

    // Receiver held off long enough for the pipeline to fill and back up.
    task automatic test_backpressure();
        int hold;
        hold = 200;
        hold_rx = 1'b1;
        fork
            begin
                repeat (hold) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            repeat (120) send_vec($urandom(), $urandom(), $urandom());
        join
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random(300);
        test_backpressure();
        test_random(200);
        i_valid <= 1'b0;
        guard = 0;
        while (unit_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PipeDepth + 20) @(posedge i_clk);
        if (n_mismatch == 0 && unit_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
